>>> sv/assert_macros.svh
// Assertion macros for the softmax core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> sv/smx_pkg.sv
// ----------------------------------------------------------------------------
// Softmax package
// Shared constants and types for the softmax core.
// ----------------------------------------------------------------------------
package smx_pkg;
    localparam int MAX_LENGTH = 64;
    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    // One job handed from the front end to the back end.
    typedef struct packed {
        logic [31:0]      value;
        logic [IDX_W-1:0] index;
        logic             last;
        logic             first;
    } job_t;
endpackage

>>> sv/smx_fifo.sv
// ----------------------------------------------------------------------------
// Softmax job queue
// Short queue decoupling the load front end from the compute back end.
// ----------------------------------------------------------------------------
module smx_fifo
    import smx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic full,
    input  logic rd_en,
    output job_t rd_data,
    output logic empty
);
    job_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wp_reg, rp_reg;
    logic [FIFO_AW:0]     cnt_reg;

    assign full    = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en && !empty)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(wr_en && !full)
                               - (FIFO_AW+1)'(rd_en && !empty);
        end
    end
endmodule

>>> sv/smx_front.sv
// ----------------------------------------------------------------------------
// Softmax front end
// Accepts scores, tracks the length count and tags each with index and flags.
// ----------------------------------------------------------------------------
module smx_front
    import smx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_len,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_score,
    output logic        job_valid,
    output job_t        job,
    input  logic        job_full
);
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] n;
    logic [7:0]       len8;

    // Zero acts as one, oversize clamps to the maximum.
    assign len8 = {1'b0, cfg_len};
    always_comb
    begin
        if (len8 == 8'd0)
            n = CNT_W'(1);
        else if (len8 > 8'(MAX_LENGTH))
            n = CNT_W'(MAX_LENGTH);
        else
            n = CNT_W'(len8);
    end

    assign in_ready   = !job_full;
    assign job_valid  = in_valid && in_ready;
    assign job.value  = in_score;
    assign job.index  = cnt_reg[IDX_W-1:0];
    assign job.first  = (cnt_reg == '0);
    assign job.last   = (cnt_reg + 1'b1 >= n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cfg_we)
            cnt_reg <= '0;
        else if (job_valid)
            cnt_reg <= job.last ? '0 : cnt_reg + 1'b1;
    end
endmodule

>>> sv/smx_div.sv
// ----------------------------------------------------------------------------
// Softmax divider
// Signed restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module smx_div
    import smx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic        done,
    output logic [31:0] quo
);
    logic [63:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic        neg_reg;
    logic [6:0]  step_reg;
    logic        busy_reg, done_reg;
    logic [32:0] trial;
    logic [32:0] rsh;
    logic [31:0] an, ad;
    logic [64:0] sq;

    assign an    = num[31] ? (~num + 1'b1) : num;
    assign ad    = den[31] ? (~den + 1'b1) : den;
    assign rsh   = {r_reg[31:0], q_reg[63]};
    assign trial = rsh - {1'b0, d_reg};
    assign busy  = busy_reg;
    assign done  = done_reg;

    // Saturate the signed quotient to 32 bits.
    assign sq = neg_reg ? (~{1'b0, q_reg} + 1'b1) : {1'b0, q_reg};
    always_comb
    begin
        if (!neg_reg && q_reg > 64'h7FFF_FFFF)
            quo = 32'h7FFF_FFFF;
        else if (neg_reg && q_reg > 64'h8000_0000)
            quo = 32'h8000_0000;
        else
            quo = sq[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 7'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= {16'd0, an, 16'd0};
            r_reg   <= '0;
            d_reg   <= ad;
            neg_reg <= num[31] ^ den[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_reg <= trial;
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= rsh;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule

>>> sv/smx_back.sv
// ----------------------------------------------------------------------------
// Softmax back end
// Stores scores, forms Taylor exponentials and sum, then normalises.
// ----------------------------------------------------------------------------
module smx_back
    import smx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_empty,
    input  job_t        job,
    output logic        job_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [39:0] out_data
);
    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_RD   = 7'b0000010,
        S_SQ   = 7'b0000100,
        S_CU   = 7'b0001000,
        S_EXP  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t           state_reg;
    logic [31:0]      mem [MAX_LENGTH];
    logic [31:0]      rd_reg;
    logic [31:0]      max_reg, sum_reg;
    logic [IDX_W-1:0] last_idx_reg, i_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             pass2_reg;
    logic             phase_div_reg;
    logic [31:0]      x_reg, sq_reg, cu_reg;
    logic [63:0]      prod_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_val;
    logic [31:0]      e_val;
    logic signed [63:0] p_s, pq;
    logic signed [31:0] sq2, cu6;
    logic             div_start, div_busy, div_done;
    logic [31:0]      div_q;
    logic [31:0]      prob_reg;
    logic [IDX_W-1:0] oidx_reg;
    logic             olast_reg, oerr_reg, ovalid_reg;
    logic             err;

    assign err     = (sum_reg == '0);
    assign job_pop = (state_reg == S_LOAD) && !job_empty;
    assign rd_addr = i_reg;

    // Truncating signed divisions by constants.
    assign p_s = $signed(prod_reg);
    assign pq  = (p_s < 0) ? -((-p_s) >>> 16) : (p_s >>> 16);
    // Adding the sign bit before the shift rounds towards zero.
    assign sq2 = ($signed(sq_reg) + $signed({31'd0, sq_reg[31]})) >>> 1;
    // The cube divided by six: high word of the reciprocal product, plus one
    // for a negative cube so that the quotient truncates towards zero.
    assign cu6 = prod_reg[63:32] + {31'd0, cu_reg[31]};
    assign e_val = 32'd65536 + x_reg + sq2 + cu6;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = job.index;
        wr_val  = job.value;
        if (job_pop)
            wr_en = 1'b1;
        else if (state_reg == S_EXP)
        begin
            wr_en   = 1'b1;
            wr_addr = i_reg;
            wr_val  = e_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_val;
        rd_reg <= mem[rd_addr];
    end

    smx_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rd_reg),
        .den   (sum_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_q)
    );

    assign div_start = (state_reg == S_DIV) && !div_busy && !div_done
                       && !err && !pass2_reg;

    assign out_valid = ovalid_reg;
    assign out_data  = {oerr_reg, olast_reg, oidx_reg, prob_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            ovalid_reg <= 1'b0;
            i_reg      <= '0;
            pass2_reg  <= 1'b0;
            max_reg    <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (job_pop)
                    begin
                        if (job.first || $signed(job.value) > $signed(max_reg))
                            max_reg <= job.value;
                        if (job.last)
                        begin
                            last_idx_reg <= job.index;
                            i_reg        <= '0;
                            sum_reg      <= '0;
                            state_reg    <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    // After the exp pass, the read feeds the divider instead.
                    state_reg <= phase_div_reg ? S_DIV : S_SQ;
                end
                S_SQ:
                begin
                    x_reg    <= rd_reg - max_reg;
                    prod_reg <= $signed(rd_reg - max_reg)
                                * $signed(rd_reg - max_reg);
                    state_reg <= S_CU;
                end
                S_CU:
                begin
                    sq_reg    <= pq[31:0];
                    prod_reg  <= $signed(pq[31:0]) * $signed(x_reg);
                    state_reg <= S_EXP;
                end
                S_EXP:
                begin
                    if (!pass2_reg)
                    begin
                        cu_reg    <= pq[31:0];
                        prod_reg  <= $signed(pq[31:0]) * $signed(32'sh2AAA_AAAB);
                        pass2_reg <= 1'b1;
                    end
                    else
                    begin
                        sum_reg <= sum_reg + e_val;
                        if (i_reg == last_idx_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_RD;
                            pass2_reg <= 1'b1;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_RD;
                            pass2_reg <= 1'b0;
                        end
                    end
                end
                S_DIV:
                begin
                    if (err || div_done)
                    begin
                        prob_reg   <= err ? 32'd0 : div_q;
                        oidx_reg   <= i_reg;
                        olast_reg  <= (i_reg == last_idx_reg);
                        oerr_reg   <= err;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                    pass2_reg <= 1'b0;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (olast_reg)
                            state_reg <= S_LOAD;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_RD;
                            pass2_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // Phase flag: set once all exponentials are written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_div_reg <= 1'b0;
        else if (state_reg == S_EXP && pass2_reg && i_reg == last_idx_reg
                 && !phase_div_reg)
            phase_div_reg <= 1'b1;
        else if (state_reg == S_OUT && out_ready && olast_reg)
            phase_div_reg <= 1'b0;
    end
endmodule

>>> sv/softmax_fixed_point_core.sv
// Flow: a vector of n scores is loaded, then per score the read, square, cube and two
// exponential steps form the exponentials, then each result is read, settles, starts
// the divider, runs 64 divider steps, finishes and is transferred out, or skips the
// divider when the exponential sum is zero. Throughput is set by the back end's divider.
// Reset (rst_n, asynchronous, active low) clears counters, state and flags;
// the value store is undefined until written, vector_length resets to 64.
// ----------------------------------------------------------------------------
// Softmax fixed-point core
// Top level: front end, job queue and back end of the softmax engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module softmax_fixed_point_core
    import smx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // score[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // probability[31:0], class_index[37:32]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // divide_error
);
    logic [6:0]  len_reg;
    logic        job_valid, job_full, job_empty, job_pop;
    job_t        job_in, job_out;
    logic [39:0] bdata;

    // Length register; writing it also restarts the load count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= 7'd64;
        else if (cfg_we)
            len_reg <= cfg_wdata;
    end

    smx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_len  (len_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_score (s_axis_tdata),
        .job_valid(job_valid),
        .job      (job_in),
        .job_full (job_full)
    );

    smx_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    smx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (bdata)
    );

    // The tlast and tuser bits travel in the back end's upper byte.
    assign m_axis_tdata = {2'd0, bdata[37:0]};
    assign m_axis_tlast = bdata[38];
    assign m_axis_tuser = bdata[39];

    `ASSERT_IMPLIES(a_no_write_full, clk, rst_n, job_full, !s_axis_tready)
    `ASSERT_NEXT(a_hold_out, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

>>> verif/tb_softmax_fixed_point_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Softmax core testbench
// Streams vectors of Q16.16 scores into the core under several vector lengths,
// predicts every normalised result in step with the accepted transfers and
// compares each output transfer, field by field, in arrival order.
// ----------------------------------------------------------------------------
module tb_softmax_fixed_point_core
    import smx_pkg::*;
();

    localparam int RANDOM_ITEMS = 270;
    localparam int STALL_LIMIT  = 20000;
    localparam int SETTLE       = 500;

    // One row of the directed plan: either a register write or a score.
    // Where typed is set, the probability and error flag of every result
    // that the row completes are fixed by hand rather than predicted.
    typedef struct packed {
        bit          is_cfg;
        logic [31:0] value;
        bit          typed;
        logic [31:0] fixed_prob;
        bit          fixed_err;
    } plan_row_t;

    typedef struct packed {
        logic [31:0]      prob;
        logic [IDX_W-1:0] class_idx;
        logic             last;
        logic             div_err;
    } softmax_out_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // score[31:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // probability[31:0], class_index[37:32]
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // divide_error

    softmax_fixed_point_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow state of the core.
    logic [31:0]  score_mem [MAX_LENGTH];
    int unsigned  loaded;
    logic [31:0]  peak_score;
    logic [6:0]   length_reg;
    softmax_out_t pending_probs [$];

    int  mismatches;
    int  scores_sent;
    int  idle_cycles;
    bit  gaps_on;

    // Truncated Taylor series for exp(x), x in Q16.16.
    function automatic logic [31:0] taylor_exp(logic [31:0] xb);
        longint x;
        longint sq;
        longint cu;
        x  = $signed(xb);
        sq = longint'(int'((x * x) / 65536));
        cu = longint'(int'((sq * x) / 65536));
        return 32'd65536 + xb + 32'(sq / 2) + 32'(cu / 6);
    endfunction

    function automatic void predict_score(logic [31:0] s, bit typed,
                                          logic [31:0] fixed_prob, bit fixed_err);
        int unsigned  n;
        logic [31:0]  total;
        logic [31:0]  e;
        longint       q;
        bit           zero_sum;
        softmax_out_t r;
        n = (length_reg == 0) ? 1 : (length_reg > MAX_LENGTH) ? MAX_LENGTH : length_reg;
        if (loaded >= MAX_LENGTH)
            loaded = 0;
        score_mem[loaded] = s;
        if (loaded == 0 || $signed(s) > $signed(peak_score))
            peak_score = s;
        loaded++;
        if (loaded < n)
            return;
        total = '0;
        for (int i = 0; i < n; i++)
        begin
            e = taylor_exp(score_mem[i] - peak_score);
            score_mem[i] = e;
            total += e;
        end
        zero_sum = (total == 0);
        for (int i = 0; i < n; i++)
        begin
            q = 0;
            if (!zero_sum)
            begin
                q = (longint'($signed(score_mem[i])) * 65536) / longint'($signed(total));
                if (q > 64'sd2147483647)
                    q = 64'sd2147483647;
                if (q < -64'sd2147483648)
                    q = -64'sd2147483648;
            end
            r.prob      = typed ? fixed_prob : q[31:0];
            r.class_idx = i[IDX_W-1:0];
            r.last      = (i + 1 == n);
            r.div_err   = typed ? fixed_err : zero_sum;
            pending_probs.push_back(r);
        end
        loaded = 0;
    endfunction

    // Offers one score, with a random gap first when gaps are on, and waits for the transfer.
    // The valid is left high afterwards so back-to-back transfers need no toggle.
    task automatic send_score(logic [31:0] s, bit typed = 0,
                              logic [31:0] fixed_prob = '0, bit fixed_err = 0);
        if (gaps_on)
            while ($urandom_range(0, 99) < 29)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_score(s, typed, fixed_prob, fixed_err);
        scores_sent++;
    endtask

    // Pauses the sender until every expected result has left the core, then
    // lets it settle so that nothing is in flight when the register changes.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_probs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_length(logic [6:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        length_reg = v;
        loaded     = 0;
    endtask

    // Output side: checks each transfer against the oldest expectation and
    // draws the next ready. A single long hold-off lets the core back up.
    int  hold_left;
    bit  hold_done;
    int  results_seen;
    always @(posedge clk)
    begin
        softmax_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_probs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: prob %h idx %0d last %b err %b",
                             m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tlast,
                             m_axis_tuser);
            end
            else
            begin
                want = pending_probs.pop_front();
                if (m_axis_tdata[31:0] !== want.prob || m_axis_tdata[37:32] !== want.class_idx
                    || m_axis_tdata[39:38] !== 2'b00 || m_axis_tlast !== want.last
                    || m_axis_tuser !== want.div_err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want prob %h idx %0d last %b err %b, got %h %0d %b %b",
                                 want.prob, want.class_idx, want.last, want.div_err,
                                 m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tlast,
                                 m_axis_tuser);
                end
            end
        end
        // The hold-off starts while the sender is offering, so the core backs up.
        if (!hold_done && scores_sent > 60 && s_axis_tvalid && pending_probs.size() != 0)
        begin
            hold_done = 1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 29);
    end

    // Watchdog: counts cycles in which neither side moves a transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_softmax_fixed_point_core failed");
            $finish;
        end
    end

    // Directed plan. Vectors of one element always normalise to exactly one;
    // two equal maxima and one element three below them sum to zero.
    plan_row_t plan [0:21] = '{
        '{1'b1, 32'd1,          1'b0, 32'd0,     1'b0},
        '{1'b0, 32'h0000_0000,  1'b1, 32'd65536, 1'b0},
        '{1'b0, 32'h7fff_ffff,  1'b1, 32'd65536, 1'b0},
        '{1'b0, 32'h8000_0000,  1'b1, 32'd65536, 1'b0},
        '{1'b1, 32'd0,          1'b0, 32'd0,     1'b0},
        '{1'b0, 32'd12345,      1'b1, 32'd65536, 1'b0},
        '{1'b1, 32'd2,          1'b0, 32'd0,     1'b0},
        '{1'b0, 32'h7fff_ffff,  1'b0, 32'd0,     1'b0},
        '{1'b0, 32'h8000_0000,  1'b0, 32'd0,     1'b0},
        '{1'b0, 32'h8000_0000,  1'b0, 32'd0,     1'b0},
        '{1'b0, 32'h7fff_ffff,  1'b0, 32'd0,     1'b0},
        '{1'b1, 32'd3,          1'b0, 32'd0,     1'b0},
        '{1'b0, 32'h0000_0000,  1'b1, 32'd0,     1'b1},
        '{1'b0, 32'h0000_0000,  1'b1, 32'd0,     1'b1},
        '{1'b0, 32'hfffd_0000,  1'b1, 32'd0,     1'b1},
        '{1'b0, 32'h0001_0000,  1'b0, 32'd0,     1'b0},
        '{1'b0, 32'hffff_0000,  1'b0, 32'd0,     1'b0},
        '{1'b0, 32'h0000_8000,  1'b0, 32'd0,     1'b0},
        '{1'b0, 32'd5,          1'b0, 32'd0,     1'b0},
        // Partly loaded vector above is dropped by this write.
        '{1'b1, 32'd2,          1'b0, 32'd0,     1'b0},
        '{1'b0, 32'h0002_0000,  1'b0, 32'd0,     1'b0},
        '{1'b0, 32'hffff_c000,  1'b0, 32'd0,     1'b0}
    };

    initial
    begin
        int          n;
        int          phase;
        int          vectors;
        int          count;
        int          mode;
        logic [31:0] base;
        logic [31:0] s;
        logic [6:0]  len_choices [9] = '{1, 2, 3, 4, 5, 6, 8, 12, 16};

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        scores_sent   = 0;
        idle_cycles   = 0;
        results_seen  = 0;
        hold_left     = 0;
        hold_done     = 0;
        gaps_on       = 1;
        loaded        = 0;
        peak_score    = '0;
        length_reg    = 7'd64;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_length(plan[i].value[6:0]);
            else
                send_score(plan[i].value, plan[i].typed, plan[i].fixed_prob,
                           plan[i].fixed_err);
        end

        phase = 0;
        while (scores_sent < RANDOM_ITEMS)
        begin
            case (phase)
                2:       write_length(7'd127);
                5:       write_length(7'd64);
                default: write_length(len_choices[$urandom_range(0, 8)]);
            endcase
            // One phase runs with no idling on either side.
            gaps_on = (phase != 1);
            n = (length_reg == 0) ? 1 : (length_reg > MAX_LENGTH) ? MAX_LENGTH : length_reg;
            vectors = (n == MAX_LENGTH) ? 1 : $urandom_range(1, 5);
            for (int v = 0; v < vectors; v++)
            begin
                mode = $urandom_range(0, 9);
                base = $urandom;
                for (int k = 0; k < n; k++)
                begin
                    if (mode < 6)
                        s = base - $urandom_range(0, 5 * 65536);
                    else if (mode < 8)
                        s = $urandom_range(0, 8 * 65536) - 4 * 65536;
                    else
                        s = $urandom;
                    send_score(s);
                end
            end
            // Now and then leave a broken vector for the next write to drop.
            if (n > 1 && $urandom_range(0, 99) < 15)
            begin
                count = $urandom_range(1, n - 1);
                for (int k = 0; k < count; k++)
                    send_score($urandom);
            end
            phase++;
        end

        gaps_on = 1;
        s_axis_tvalid <= 1'b0;
        while (pending_probs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (pending_probs.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("tb_softmax_fixed_point_core passed");
        else
            $display("tb_softmax_fixed_point_core failed");
        $finish;
    end
endmodule
